@@ rtl/assert_macros.svh @@
// Assertion macros shared by the relocation patcher RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpat assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpat assertion failed");

`endif

@@ rtl/rpat_pkg.sv @@
// Package for the relocation patcher: opcodes, status codes, payload structs and constants.
// Depends on nothing; imported by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rpat_pkg;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned POOL_W = 28;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_ADDR32    = 4'd1,
    OP_LO        = 4'd2,
    OP_HI        = 4'd3,
    OP_HA        = 4'd4,
    OP_DTPMOD    = 4'd5,
    OP_DTPREL    = 4'd6,
    OP_RELHA     = 4'd7,
    OP_RELHI     = 4'd8,
    OP_RELLO     = 4'd9,
    OP_REL14     = 4'd10,
    OP_REL24     = 4'd11,
    OP_SDA21     = 4'd12,
    OP_SDA_OTHER = 4'd13,
    OP_UNSUPP    = 4'd14
  } rpat_op_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SDA_REG   = 4'd1,
    ST_SDA_UNIMP = 4'd2,
    ST_RANGE     = 4'd3,
    ST_ALIGN     = 4'd4,
    ST_SIGN      = 4'd5,
    ST_POOL_OUT  = 4'd6,
    ST_TOO_FAR   = 4'd7,
    ST_UNSUPP    = 4'd8
  } rpat_status_e;

  typedef enum logic [1:0] {
    SZ_NONE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } rpat_size_e;

  typedef enum logic [2:0] {
    REG_EXEC_MODE  = 3'd0,
    REG_SDA_BASE   = 3'd1,
    REG_SDA2_BASE  = 3'd2,
    REG_PRE_START  = 3'd3,
    REG_PRE_SLOTS  = 3'd4,
    REG_POST_START = 3'd5,
    REG_POST_SLOTS = 3'd6
  } rpat_reg_e;

  localparam logic [31:0] REL14_KEEP  = 32'hFFBF0003;
  localparam logic [31:0] REL24_KEEP  = 32'hFC000003;
  localparam logic [31:0] REL24_DISP  = 32'h03FFFFFC;
  localparam logic [31:0] REL24_REACH = 32'h01FFFFFC;
  localparam logic [31:0] REL14_REACH = 32'h00007FFC;
  localparam logic [31:0] REL14_DISP  = 32'h0000FFFC;
  localparam logic [31:0] HA_ROUND    = 32'h00008000;
  localparam logic [31:0] REL24_SIGN  = 32'hFE000000;
  localparam logic [31:0] REL14_SIGN  = 32'hFFFF8000;
  localparam logic [31:0] LIS_R11     = 32'h3D600000;
  localparam logic [31:0] ORI_R11     = 32'h616B0000;
  localparam logic [31:0] MTCTR_R11   = 32'h7D6903A6;
  localparam logic [31:0] BCTR_WORD   = 32'h4E800420;
  localparam logic [31:0] SLOT_STEP   = 32'd16;
  localparam logic [4:0]  SDA_RA_R2   = 5'd2;
  localparam logic [4:0]  SDA_RA_R13  = 5'd13;
  localparam logic [4:0]  SDA_RA_R0   = 5'd0;
  localparam logic [2:0]  TRAMP_BEATS = 3'd4;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] target_address;
    logic [31:0] target_word;
    logic [31:0] symbol_value;
    logic [31:0] addend;
    logic        is_weak;
    logic [15:0] tls_module;
  } rpat_req_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [1:0]  write_size;
    logic [3:0]  status;
    logic        last;
  } rpat_rsp_t;

  typedef struct packed {
    logic        exec_mode;
    logic [31:0] sda_base;
    logic [31:0] sda2_base;
  } rpat_cfg_t;

  typedef struct packed {
    logic [31:0]       pre_next;
    logic [POOL_W-1:0] pre_left;
    logic [31:0]       post_next;
    logic [POOL_W-1:0] post_left;
  } rpat_pool_t;

  typedef struct packed {
    logic post;
    logic pre;
  } rpat_take_t;

  typedef struct packed {
    rpat_rsp_t   fin;
    logic        tramp;
    logic [31:0] slot;
    logic [31:0] value;
  } rpat_job_t;

  // True when the displacement's upper bits do not all match its sign bit.
  function automatic logic sign_bits_bad(input logic [31:0] d, input logic [31:0] mask);
    logic bad;
    if (d[31]) begin
      bad = (d & mask) != mask;
    end else begin
      bad = (d & mask) != 32'd0;
    end
    return bad;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rpat_stream_if.sv @@
// Valid/ready stream interface used for the request and result channels.
// Depends on nothing; the payload type is chosen where the interface is instantiated.
`timescale 1ns / 1ps
`default_nettype none

interface rpat_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/rpat_regs.sv @@
// APB register file and trampoline pool pointers/counters of the relocation patcher.
// Depends on rpat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpat_regs import rpat_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              take_en_i,
  input  wire rpat_take_t        take_i,
  output rpat_cfg_t              cfg_o,
  output rpat_pool_t             pool_o
);

  logic              exec_mode_q;
  logic [31:0]       sda_base_q;
  logic [31:0]       sda2_base_q;
  logic [31:0]       pre_start_q;
  logic [POOL_W-1:0] pre_slots_q;
  logic [31:0]       post_start_q;
  logic [POOL_W-1:0] post_slots_q;
  rpat_pool_t        pool_q;
  rpat_pool_t        pool_d;
  logic              wr_en;
  rpat_reg_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = rpat_reg_e'(paddr[APB_AW-1:2]);

  always_comb begin
    pool_d = pool_q;
    if (take_en_i && take_i.post) begin
      pool_d.post_next = pool_q.post_next + SLOT_STEP;
      pool_d.post_left = pool_q.post_left - POOL_W'(1);
    end
    if (take_en_i && take_i.pre) begin
      pool_d.pre_next = pool_q.pre_next - SLOT_STEP;
      pool_d.pre_left = pool_q.pre_left - POOL_W'(1);
    end
    if (wr_en) begin
      unique case (idx)
        REG_PRE_START:  pool_d.pre_next  = pwdata;
        REG_PRE_SLOTS:  pool_d.pre_left  = pwdata[POOL_W-1:0];
        REG_POST_START: pool_d.post_next = pwdata;
        REG_POST_SLOTS: pool_d.post_left = pwdata[POOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_mode_q  <= 1'b0;
      sda_base_q   <= '0;
      sda2_base_q  <= '0;
      pre_start_q  <= '0;
      pre_slots_q  <= '0;
      post_start_q <= '0;
      post_slots_q <= '0;
      pool_q       <= '0;
    end else begin
      pool_q <= pool_d;
      if (wr_en) begin
        unique case (idx)
          REG_EXEC_MODE:  exec_mode_q  <= pwdata[0];
          REG_SDA_BASE:   sda_base_q   <= pwdata;
          REG_SDA2_BASE:  sda2_base_q  <= pwdata;
          REG_PRE_START:  pre_start_q  <= pwdata;
          REG_PRE_SLOTS:  pre_slots_q  <= pwdata[POOL_W-1:0];
          REG_POST_START: post_start_q <= pwdata;
          REG_POST_SLOTS: post_slots_q <= pwdata[POOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_EXEC_MODE:  prdata = {31'd0, exec_mode_q};
      REG_SDA_BASE:   prdata = sda_base_q;
      REG_SDA2_BASE:  prdata = sda2_base_q;
      REG_PRE_START:  prdata = pre_start_q;
      REG_PRE_SLOTS:  prdata = {{(32-POOL_W){1'b0}}, pre_slots_q};
      REG_POST_START: prdata = post_start_q;
      REG_POST_SLOTS: prdata = {{(32-POOL_W){1'b0}}, post_slots_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o.exec_mode = exec_mode_q;
  assign cfg_o.sda_base  = sda_base_q;
  assign cfg_o.sda2_base = sda2_base_q;
  assign pool_o          = pool_q;

endmodule

`default_nettype wire

@@ rtl/rpat_eval.sv @@
// Evaluates one registered relocation: patched write, status, trampoline choice and pool use.
// Depends on rpat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpat_eval import rpat_pkg::*; (
  input  wire rpat_req_t  req_i,
  input  wire rpat_cfg_t  cfg_i,
  input  wire rpat_pool_t pool_i,
  output rpat_job_t       job_o,
  output rpat_take_t      take_o
);

  logic [31:0] tgt;
  logic [31:0] value;
  logic [31:0] rel;
  logic [31:0] v_br;
  logic [31:0] d_br;
  logic [31:0] bd;
  logic [31:0] post_d;
  logic [31:0] pre_d;
  logic [31:0] sda_v;
  logic [4:0]  ra;
  logic        pool_fail;

  localparam logic signed [31:0] R14_HI = REL14_REACH;
  localparam logic signed [31:0] R14_LO = -REL14_REACH;
  localparam logic signed [31:0] R24_HI = REL24_REACH;
  localparam logic signed [31:0] R24_LO = -REL24_REACH;

  assign tgt    = req_i.target_address;
  assign value  = req_i.symbol_value + req_i.addend;
  assign rel    = value - tgt;
  assign v_br   = (req_i.is_weak && req_i.symbol_value == 32'd0) ?
                  tgt + req_i.addend : value;
  assign d_br   = v_br - tgt;
  assign post_d = pool_i.post_next - tgt;
  assign pre_d  = tgt - pool_i.pre_next;
  assign ra     = req_i.target_word[20:16];

  always_comb begin
    job_o            = '0;
    job_o.fin.last   = 1'b1;
    job_o.value      = v_br;
    take_o           = '0;
    pool_fail        = 1'b0;
    bd               = d_br;
    sda_v            = value;
    if (ra == SDA_RA_R2) begin
      sda_v = value - cfg_i.sda2_base;
    end else if (ra == SDA_RA_R13) begin
      sda_v = value - cfg_i.sda_base;
    end

    if (cfg_i.exec_mode && rpat_op_e'(req_i.op) == OP_SDA21) begin
      if (ra != SDA_RA_R2 && ra != SDA_RA_R13 && ra != SDA_RA_R0) begin
        job_o.fin.status = ST_SDA_REG;
      end else begin
        job_o.fin.write_address = tgt;
        job_o.fin.write_data    = {req_i.target_word[31:16], sda_v[15:0]};
        job_o.fin.write_size    = SZ_WORD;
      end
    end else if (cfg_i.exec_mode && rpat_op_e'(req_i.op) == OP_SDA_OTHER) begin
      job_o.fin.status = ST_SDA_UNIMP;
    end else begin
      unique case (rpat_op_e'(req_i.op))
        OP_NONE: ;
        OP_ADDR32, OP_DTPREL: begin
          job_o.fin.write_address = tgt;
          job_o.fin.write_data    = value;
          job_o.fin.write_size    = SZ_WORD;
        end
        OP_LO: begin
          job_o.fin.write_address = tgt;
          job_o.fin.write_data    = {16'd0, value[15:0]};
          job_o.fin.write_size    = SZ_HALF;
        end
        OP_HI: begin
          job_o.fin.write_address = tgt;
          job_o.fin.write_data    = {16'd0, value[31:16]};
          job_o.fin.write_size    = SZ_HALF;
        end
        OP_HA: begin
          job_o.fin.write_address = tgt;
          job_o.fin.write_data    = {16'd0, 16'((value + HA_ROUND) >> 16)};
          job_o.fin.write_size    = SZ_HALF;
        end
        OP_DTPMOD: begin
          job_o.fin.write_address = tgt;
          job_o.fin.write_data    = {16'd0, req_i.tls_module};
          job_o.fin.write_size    = SZ_WORD;
        end
        OP_RELHA: begin
          job_o.fin.write_address = tgt;
          job_o.fin.write_data    = {16'd0, 16'((rel + HA_ROUND) >> 16)};
          job_o.fin.write_size    = SZ_HALF;
        end
        OP_RELHI: begin
          job_o.fin.write_address = tgt;
          job_o.fin.write_data    = {16'd0, rel[31:16]};
          job_o.fin.write_size    = SZ_HALF;
        end
        OP_RELLO: begin
          job_o.fin.write_address = tgt;
          job_o.fin.write_data    = {16'd0, rel[15:0]};
          job_o.fin.write_size    = SZ_HALF;
        end
        OP_REL14: begin
          if ($signed(d_br) > R14_HI || $signed(d_br) < R14_LO) begin
            job_o.fin.status = ST_RANGE;
          end else if (d_br[1:0] != 2'b00) begin
            job_o.fin.status = ST_ALIGN;
          end else if (sign_bits_bad(d_br, REL14_SIGN)) begin
            job_o.fin.status = ST_SIGN;
          end else begin
            job_o.fin.write_address = tgt;
            job_o.fin.write_data    = (req_i.target_word & REL14_KEEP) | (d_br & REL14_DISP);
            job_o.fin.write_size    = SZ_WORD;
          end
        end
        OP_REL24: begin
          if ($signed(d_br) > R24_HI || $signed(d_br) < R24_LO) begin
            if (post_d <= REL24_REACH) begin
              if (pool_i.post_left == '0) begin
                pool_fail = 1'b1;
                job_o.fin.status = ST_POOL_OUT;
              end else begin
                take_o.post = 1'b1;
                job_o.tramp = 1'b1;
                job_o.slot  = pool_i.post_next;
              end
            end else if (pre_d <= REL24_REACH) begin
              if (pool_i.pre_left == '0) begin
                pool_fail = 1'b1;
                job_o.fin.status = ST_POOL_OUT;
              end else begin
                take_o.pre  = 1'b1;
                job_o.tramp = 1'b1;
                job_o.slot  = pool_i.pre_next;
              end
            end else begin
              pool_fail = 1'b1;
              job_o.fin.status = ST_TOO_FAR;
            end
            bd = job_o.slot - tgt;
          end
          if (!pool_fail) begin
            if (bd[1:0] != 2'b00) begin
              job_o.fin.status = ST_ALIGN;
            end else if (sign_bits_bad(bd, REL24_SIGN)) begin
              job_o.fin.status = ST_SIGN;
            end else begin
              job_o.fin.write_address = tgt;
              job_o.fin.write_data    = (req_i.target_word & REL24_KEEP) | (bd & REL24_DISP);
              job_o.fin.write_size    = SZ_WORD;
            end
          end
        end
        default: job_o.fin.status = ST_UNSUPP;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/rpat_beats.sv @@
// Holds one evaluated relocation and emits its trampoline words and final write into the
// result register, one request per cycle while the result side accepts. Depends on rpat_pkg and rpat_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module rpat_beats import rpat_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       job_valid_i,
  input  wire rpat_job_t  job_i,
  output logic            job_ready_o,
  rpat_stream_if.source   rsp_o
);

  rpat_job_t  job_q;
  logic       job_valid_q;
  logic       job_valid_d;
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;
  rpat_rsp_t  out_q;
  logic       out_valid_q;
  logic       out_valid_d;
  rpat_rsp_t  beat;
  logic       is_final;
  logic       out_free;
  logic       advance;
  logic       job_load;

  assign is_final    = !job_q.tramp || cnt_q == TRAMP_BEATS;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = job_valid_q && out_free;
  assign job_ready_o = !job_valid_q || (advance && is_final);
  assign job_load    = job_valid_i && job_ready_o;

  always_comb begin
    beat               = job_q.fin;
    if (!is_final) begin
      beat.write_address = job_q.slot + 32'({cnt_q[1:0], 2'b00});
      beat.write_size    = SZ_WORD;
      beat.status        = ST_OK;
      beat.last          = 1'b0;
      unique case (cnt_q[1:0])
        2'd0:    beat.write_data = LIS_R11 | {16'd0, job_q.value[31:16]};
        2'd1:    beat.write_data = ORI_R11 | {16'd0, job_q.value[15:0]};
        2'd2:    beat.write_data = MTCTR_R11;
        default: beat.write_data = BCTR_WORD;
      endcase
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    cnt_d       = cnt_q;
    if (advance && !is_final) begin
      cnt_d = cnt_q + 3'd1;
    end
    if (job_ready_o) begin
      job_valid_d = job_valid_i;
      cnt_d       = 3'd0;
    end
    out_valid_d = advance || (out_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_q <= job_i;
    end
    if (advance) begin
      out_q <= beat;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

`default_nettype wire

@@ rtl/ppc_relocation_patcher_core.sv @@
// Top level of the PowerPC relocation patcher: request register, evaluation, result sequencer.
// Depends on rpat_pkg, rpat_stream_if, rpat_regs, rpat_eval, rpat_beats, assert_macros.svh.
//
//  channel   direction  kind            payload
//  req_i     in         valid/ready     rpat_req_t: one relocation
//  rsp_o     out        valid/ready     rpat_rsp_t: one write request and status
//  apb       in         APB slave       seven configuration registers at 4*i
//
// A relocation passes through the request, job and result registers before its first result.
// One relocation is taken every cycle while nothing stalls; a trampolined branch drives five
// results and holds the request register until its final result enters the result register.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result side fills the result, job and request registers, then drops req_i.ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ppc_relocation_patcher_core import rpat_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  rpat_stream_if.sink            req_i,
  rpat_stream_if.source          rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  rpat_req_t  in_q;
  logic       in_valid_q;
  logic       in_valid_d;
  logic       in_load;
  logic       job_ready;
  logic       job_load;
  rpat_cfg_t  cfg;
  rpat_pool_t pool;
  rpat_job_t  job;
  rpat_take_t take;

  assign req_i.ready = !in_valid_q || job_ready;
  assign in_load     = req_i.valid && req_i.ready;
  assign job_load    = in_valid_q && job_ready;
  assign in_valid_d  = (in_valid_q && !job_ready) || in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= req_i.data;
    end
  end

  rpat_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .take_en_i (job_load),
    .take_i    (take),
    .cfg_o     (cfg),
    .pool_o    (pool)
  );

  rpat_eval u_eval (
    .req_i  (in_q),
    .cfg_i  (cfg),
    .pool_i (pool),
    .job_o  (job),
    .take_o (take)
  );

  rpat_beats u_beats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (in_valid_q),
    .job_i       (job),
    .job_ready_o (job_ready),
    .rsp_o       (rsp_o)
  );

  `RPAT_ASSERT_NEXT(a_post_slot_used, clk_i, rst_ni, job_load && take.post && !(psel && penable && pwrite), pool.post_left == $past(pool.post_left) - 28'd1)
  `RPAT_ASSERT_IMP(a_one_pool, clk_i, rst_ni, job_load, !(take.post && take.pre))
  `RPAT_ASSERT_IMP(a_tramp_word, clk_i, rst_ni, rsp_o.valid && !rsp_o.data.last, rsp_o.data.write_size == SZ_WORD && rsp_o.data.status == ST_OK)

endmodule

`default_nettype wire

@@ tb/ppc_relocation_patcher_core_test.sv @@
// Self-checking testbench for ppc_relocation_patcher_core: directed and random relocations,
// checked against a scoreboard that predicts every write request and the trampoline pools.
// Depends on rpat_pkg, rpat_stream_if and ppc_relocation_patcher_core from the RTL.
`timescale 1ns / 1ps

module ppc_relocation_patcher_core_test;
  import rpat_pkg::*;

  localparam logic [3:0] OP_RESERVED = 4'd15;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 60;

  typedef struct {
    logic              exec_mode;
    logic [31:0]       sda_base;
    logic [31:0]       sda2_base;
    logic [31:0]       pre_start;
    logic [POOL_W-1:0] pre_slots;
    logic [31:0]       post_start;
    logic [POOL_W-1:0] post_slots;
    logic [31:0]       hot;
  } pool_setting_t;

  class patch_scoreboard;
    logic              exec_mode;
    logic [31:0]       sda_base;
    logic [31:0]       sda2_base;
    logic [31:0]       pre_next;
    logic [31:0]       post_next;
    logic [POOL_W-1:0] pre_left;
    logic [POOL_W-1:0] post_left;
    rpat_rsp_t         pending_q[$];
    int unsigned       errors;

    function new();
      exec_mode = 1'b0;
      sda_base  = '0;
      sda2_base = '0;
      pre_next  = '0;
      post_next = '0;
      pre_left  = '0;
      post_left = '0;
      errors    = 0;
    endfunction

    function void configure(rpat_reg_e idx, logic [31:0] v);
      case (idx)
        REG_EXEC_MODE:  exec_mode = v[0];
        REG_SDA_BASE:   sda_base = v;
        REG_SDA2_BASE:  sda2_base = v;
        REG_PRE_START:  pre_next = v;
        REG_PRE_SLOTS:  pre_left = v[POOL_W-1:0];
        REG_POST_START: post_next = v;
        REG_POST_SLOTS: post_left = v[POOL_W-1:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [31:0] addr, logic [31:0] data, rpat_size_e size,
                       rpat_status_e st, logic last);
      rpat_rsp_t w;
      w.write_address = addr;
      w.write_data    = data;
      w.write_size    = size;
      w.status        = st;
      w.last          = last;
      pending_q.push_back(w);
    endfunction

    function void reject(rpat_status_e st);
      emit('0, '0, SZ_NONE, st, 1'b1);
    endfunction

    function void note_relocation(rpat_req_t r);
      logic [31:0] tgt;
      logic [31:0] value;
      logic [31:0] rel;
      logic [31:0] adj;
      logic [31:0] disp;
      logic [31:0] slot;
      logic [4:0]  ra;
      tgt   = r.target_address;
      value = r.symbol_value + r.addend;
      rel   = value - tgt;
      if (exec_mode && r.op == OP_SDA21) begin
        ra = r.target_word[20:16];
        if (ra == SDA_RA_R2) begin
          value = value - sda2_base;
        end else if (ra == SDA_RA_R13) begin
          value = value - sda_base;
        end else if (ra != SDA_RA_R0) begin
          reject(ST_SDA_REG);
          return;
        end
        emit(tgt, {r.target_word[31:16], value[15:0]}, SZ_WORD, ST_OK, 1'b1);
        return;
      end
      if (exec_mode && r.op == OP_SDA_OTHER) begin
        reject(ST_SDA_UNIMP);
        return;
      end
      case (r.op)
        OP_NONE:   emit('0, '0, SZ_NONE, ST_OK, 1'b1);
        OP_ADDR32: emit(tgt, value, SZ_WORD, ST_OK, 1'b1);
        OP_LO:     emit(tgt, {16'h0, value[15:0]}, SZ_HALF, ST_OK, 1'b1);
        OP_HI:     emit(tgt, {16'h0, value[31:16]}, SZ_HALF, ST_OK, 1'b1);
        OP_HA: begin
          adj = value + HA_ROUND;
          emit(tgt, {16'h0, adj[31:16]}, SZ_HALF, ST_OK, 1'b1);
        end
        OP_DTPMOD: emit(tgt, {16'h0, r.tls_module}, SZ_WORD, ST_OK, 1'b1);
        OP_DTPREL: emit(tgt, value, SZ_WORD, ST_OK, 1'b1);
        OP_RELHA: begin
          adj = rel + HA_ROUND;
          emit(tgt, {16'h0, adj[31:16]}, SZ_HALF, ST_OK, 1'b1);
        end
        OP_RELHI:  emit(tgt, {16'h0, rel[31:16]}, SZ_HALF, ST_OK, 1'b1);
        OP_RELLO:  emit(tgt, {16'h0, rel[15:0]}, SZ_HALF, ST_OK, 1'b1);
        OP_REL14: begin
          if (r.is_weak && r.symbol_value == '0) value = tgt + r.addend;
          disp = value - tgt;
          if ($signed(disp) > $signed(REL14_REACH) || $signed(disp) < -$signed(REL14_REACH)) begin
            reject(ST_RANGE);
          end else if (disp[1:0] != 2'b00) begin
            reject(ST_ALIGN);
          end else if (disp[31] ? (disp & REL14_SIGN) != REL14_SIGN
                                : (disp & REL14_SIGN) != '0) begin
            reject(ST_SIGN);
          end else begin
            emit(tgt, (r.target_word & REL14_KEEP) | (disp & REL14_DISP), SZ_WORD, ST_OK, 1'b1);
          end
        end
        OP_REL24: begin
          if (r.is_weak && r.symbol_value == '0) value = tgt + r.addend;
          disp = value - tgt;
          if ($signed(disp) > $signed(REL24_REACH) || $signed(disp) < -$signed(REL24_REACH)) begin
            if (post_next - tgt <= REL24_REACH) begin
              if (post_left == '0) begin
                reject(ST_POOL_OUT);
                return;
              end
              slot      = post_next;
              post_next = post_next + SLOT_STEP;
              post_left = post_left - 1'b1;
            end else if (tgt - pre_next <= REL24_REACH) begin
              if (pre_left == '0) begin
                reject(ST_POOL_OUT);
                return;
              end
              slot     = pre_next;
              pre_next = pre_next - SLOT_STEP;
              pre_left = pre_left - 1'b1;
            end else begin
              reject(ST_TOO_FAR);
              return;
            end
            emit(slot, LIS_R11 | {16'h0, value[31:16]}, SZ_WORD, ST_OK, 1'b0);
            emit(slot + 32'd4, ORI_R11 | {16'h0, value[15:0]}, SZ_WORD, ST_OK, 1'b0);
            emit(slot + 32'd8, MTCTR_R11, SZ_WORD, ST_OK, 1'b0);
            emit(slot + 32'd12, BCTR_WORD, SZ_WORD, ST_OK, 1'b0);
            disp = slot - tgt;
          end
          if (disp[1:0] != 2'b00) begin
            reject(ST_ALIGN);
          end else if (disp[31] ? (disp & REL24_SIGN) != REL24_SIGN
                                : (disp & REL24_SIGN) != '0) begin
            reject(ST_SIGN);
          end else begin
            emit(tgt, (r.target_word & REL24_KEEP) | (disp & REL24_DISP), SZ_WORD, ST_OK, 1'b1);
          end
        end
        default: reject(ST_UNSUPP);
      endcase
    endfunction

    function void check_write(rpat_rsp_t got);
      rpat_rsp_t exp;
      if (pending_q.size() == 0) begin
        $error("unexpected write request: address %h data %h", got.write_address,
               got.write_data);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.write_address !== exp.write_address) begin
        $error("write_address: expected %h, got %h", exp.write_address, got.write_address);
        errors++;
      end
      if (got.write_data !== exp.write_data) begin
        $error("write_data: expected %h, got %h", exp.write_data, got.write_data);
        errors++;
      end
      if (got.write_size !== exp.write_size) begin
        $error("write_size: expected %0d, got %0d", exp.write_size, got.write_size);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              steady = 1'b0;
  int unsigned       idle_cycles = 0;
  patch_scoreboard   sb = new();

  rpat_stream_if #(.T(rpat_req_t)) req_if ();
  rpat_stream_if #(.T(rpat_rsp_t)) rsp_if ();

  ppc_relocation_patcher_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  initial rsp_if.ready = 1'b0;

  always @(negedge clk_i) begin
    rsp_if.ready <= steady || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk_i) begin
    idle_cycles++;
    if (rst_ni && req_if.valid && req_if.ready) begin
      sb.note_relocation(req_if.data);
      idle_cycles = 0;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_write(rsp_if.data);
      idle_cycles = 0;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic rpat_req_t relocation(logic [3:0] op, logic [31:0] tgt, logic [31:0] word,
                                           logic [31:0] sym, logic [31:0] add,
                                           logic weak_flag, logic [15:0] tls);
    rpat_req_t r;
    r.op             = op;
    r.target_address = tgt;
    r.target_word    = word;
    r.symbol_value   = sym;
    r.addend         = add;
    r.is_weak        = weak_flag;
    r.tls_module     = tls;
    return r;
  endfunction

  function automatic rpat_req_t random_relocation(logic [31:0] hot);
    rpat_req_t   r;
    int unsigned pick;
    logic [31:0] offset;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.op = OP_REL24;
    end else if (pick < 45) begin
      r.op = OP_REL14;
    end else if (pick < 55) begin
      r.op = OP_SDA21;
    end else begin
      r.op = 4'($urandom_range(0, 15));
    end
    if ($urandom_range(0, 3) == 0) begin
      r.target_address = $urandom;
    end else begin
      r.target_address = hot + $urandom_range(0, 32'h05FF_FFFF) - 32'h0300_0000;
    end
    if ($urandom_range(0, 6) != 0) r.target_address[1:0] = 2'b00;
    r.target_word = $urandom;
    if (r.op == OP_SDA21) begin
      case ($urandom_range(0, 3))
        0: r.target_word[20:16] = SDA_RA_R0;
        1: r.target_word[20:16] = SDA_RA_R2;
        2: r.target_word[20:16] = SDA_RA_R13;
        default: ;
      endcase
    end
    case ($urandom_range(0, 3))
      0: r.addend = '0;
      3: r.addend = $urandom;
      default: r.addend = $urandom_range(0, 32'hFFFF) - 32'h8000;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      r.symbol_value = '0;
    end else if (pick < 7) begin
      if (r.op == OP_REL14) begin
        offset = $urandom_range(0, 32'h11000) - 32'h8800;
      end else begin
        offset = $urandom_range(0, 32'h0440_0000) - 32'h0220_0000;
      end
      if ($urandom_range(0, 6) != 0) offset[1:0] = 2'b00;
      r.symbol_value = r.target_address - r.addend + offset;
    end else begin
      r.symbol_value = $urandom;
    end
    r.is_weak    = 1'($urandom_range(0, 1));
    r.tls_module = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  task automatic push_request(input rpat_req_t item);
    while (!steady && $urandom_range(0, 99) < 21) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  task automatic write_register(input rpat_reg_e idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.configure(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input pool_setting_t s);
    write_register(REG_EXEC_MODE, {31'h0, s.exec_mode});
    write_register(REG_SDA_BASE, s.sda_base);
    write_register(REG_SDA2_BASE, s.sda2_base);
    write_register(REG_PRE_START, s.pre_start);
    write_register(REG_PRE_SLOTS, {4'h0, s.pre_slots});
    write_register(REG_POST_START, s.post_start);
    write_register(REG_POST_SLOTS, {4'h0, s.post_slots});
  endtask

  initial begin
    pool_setting_t settings[PHASES];
    pool_setting_t directed;
    logic [31:0]   post_start;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;

    directed    = '{1'b1, 32'h1000_8000, 32'h1001_0000, 32'h0FF0_0000, 28'd1,
                    32'h1010_0000, 28'd2, 32'h1000_0000};
    settings[0] = '{1'b1, $urandom, $urandom, 32'h0FF0_0000, 28'd6,
                    32'h1010_0000, 28'd4, 32'h1000_0000};
    settings[1] = '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 28'hFFF_FFFF,
                    32'h0000_0000, 28'hFFF_FFFF, 32'h0000_0000};
    settings[2] = '{1'b1, 32'h0, 32'h0, 32'h8000_0000, 28'hFFF_FFFF,
                    32'h8000_0010, 28'd0, 32'h8000_0000};
    post_start  = $urandom & 32'hFFFF_FFF0;
    settings[3] = '{1'b1, $urandom, $urandom, $urandom & 32'hFFFF_FFF0,
                    28'($urandom_range(1, 8)), post_start, 28'($urandom_range(1, 8)),
                    post_start};
    settings[4] = '{1'b0, $urandom, $urandom, 32'h0000_0000, 28'd3,
                    32'hFFFF_FFF0, 28'hFFF_FFFF, 32'h0000_0000};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_request(relocation(OP_NONE, '0, '0, '0, '0, 1'b0, '0));
    push_request(relocation(OP_ADDR32, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 1'b1, 16'hFFFF));
    push_request(relocation(OP_LO, 32'h0000_1000, '0, 32'h1234_5678, 32'h1, 1'b0, '0));
    push_request(relocation(OP_HI, 32'h0000_1002, '0, 32'hFFFF_0000, 32'hFFFF, 1'b0, '0));
    push_request(relocation(OP_HA, 32'h0000_1004, '0, 32'h1234_8000, '0, 1'b0, '0));
    push_request(relocation(OP_DTPMOD, 32'h0000_2000, '0, '0, '0, 1'b0, 16'hFFFF));
    push_request(relocation(OP_DTPREL, 32'h0000_2004, '0, 32'h100, 32'hFFFF_FF00, 1'b0,
                            16'h1234));
    push_request(relocation(OP_RELHA, 32'h1000_0000, '0, 32'h0000_8000, '0, 1'b0, '0));
    push_request(relocation(OP_RELHI, 32'h1000_0000, '0, 32'h2000_0000, 32'h1234, 1'b0, '0));
    push_request(relocation(OP_RELLO, 32'h1000_0010, '0, 32'h1000_0000, '0, 1'b0, '0));
    push_request(relocation(OP_SDA21, 32'h1000_0020, 32'h380D_0000, 32'h1000_8010, '0, 1'b0,
                            '0));
    push_request(relocation(OP_SDA_OTHER, 32'h1000_0024, '0, '0, '0, 1'b0, '0));
    push_request(relocation(OP_UNSUPP, 32'h1000_0028, '0, '0, '0, 1'b0, '0));
    push_request(relocation(OP_RESERVED, 32'h1000_002C, '0, '0, '0, 1'b0, '0));
    push_request(relocation(OP_REL24, 32'h4000_0000, 32'h4800_0001, '0, '0, 1'b0, '0));
    push_request(relocation(OP_REL24, 32'hFFFF_FF00, 32'h4800_0001, 32'h4000_0000, '0, 1'b0,
                            '0));
    wait_results_done();
    apply_setting(directed);
    push_request(relocation(OP_SDA21, 32'h1000_0020, 32'h380D_0000, 32'h1000_8010, '0, 1'b0,
                            '0));
    push_request(relocation(OP_SDA21, 32'h1000_0020, 32'h3802_0000, 32'h1000_8010, '0, 1'b0,
                            '0));
    push_request(relocation(OP_SDA21, 32'h1000_0020, 32'h3805_0000, 32'h1000_8010, '0, 1'b0,
                            '0));
    push_request(relocation(OP_SDA_OTHER, 32'h1000_0024, '0, '0, '0, 1'b0, '0));
    push_request(relocation(OP_REL14, 32'h0000_2000, 32'h4182_0000, '0, 32'h8, 1'b1, '0));
    push_request(relocation(OP_REL14, 32'h0000_2000, 32'h4182_0000, 32'h0000_A000, '0, 1'b0,
                            '0));
    push_request(relocation(OP_REL14, 32'h0000_2000, 32'hFFFF_FFFF, 32'h0000_2006, '0, 1'b0,
                            '0));
    push_request(relocation(OP_REL24, 32'h1000_0000, 32'h4800_0001, 32'h8000_0000, 32'h10,
                            1'b0, '0));
    push_request(relocation(OP_REL24, 32'h1020_0000, 32'h4BFF_FFFF, '0, 32'h4000_0000, 1'b1,
                            '0));
    push_request(relocation(OP_REL24, 32'h1000_0002, 32'h4800_0001, 32'h7000_0000, '0, 1'b0,
                            '0));
    push_request(relocation(OP_REL24, 32'h1000_0000, 32'h4800_0001, 32'h7000_0000, '0, 1'b0,
                            '0));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      apply_setting(settings[ph]);
      steady = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == PHASE_ITEMS / 2) wait_results_done();
        push_request(random_relocation(settings[ph].hot));
      end
    end
    steady = 1'b0;
    wait_results_done();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
